### src/la_pkg.sv
// Shared constants and address helper for the line assembler.
`timescale 1ns / 1ps

package la_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int LEN_W     = 6;

  localparam logic [LEN_W-1:0] MAX_LINE   = 6'd62;
  localparam logic [7:0]       TERM_RESET = 8'd10;
  localparam logic [7:0]       NUL_BYTE   = 8'd0;

  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(BUF_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(BUF_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### src/la_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module la_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/line_assembler_top.sv
// Line assembler top level: byte stream in, terminated line runs out.
//
//   channel  | handshake                      | payload
//   s_axis   | s_axis_tvalid / s_axis_tready  | tdata chunk byte, tlast end of chunk,
//            |                                | tuser skip
//   m_axis   | m_axis_tvalid / m_axis_tready  | tdata line byte/length/overflow,
//            |                                | tlast run end, tuser line found
//   cfg      | cfg_we                         | cfg_data terminator byte
//
// A byte that does not end a chunk is stored with at most one RAM write.
// A chunk end starts a terminator scan over the stored bytes (one RAM read a cycle),
// then each line byte is read from RAM and placed in the output register, or a
// single no-line or empty-line result is loaded; either may wait on an output stall.
// The line buffer is a circular RAM tracked by a head pointer and a fill count, so
// reset needs no clearing pass. The input is held off from chunk end to run end.
`timescale 1ns / 1ps

module line_assembler_top import la_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] chunk_byte
  input  logic        s_axis_tlast,   // end_of_chunk
  input  logic        s_axis_tuser,   // skip_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] line_byte, [13:8] line_length,
                                      // [14] overflow_seen, [15] zero
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser,   // line_found
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEARCH   = 3'd1;
  localparam logic [2:0] S_EMIT_ONE = 3'd2;
  localparam logic [2:0] S_EMIT_RD  = 3'd3;
  localparam logic [2:0] S_EMIT_WR  = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  idx;
  logic              rd_pend;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic              stopped;
  logic              dropped;
  logic [7:0]        term;
  logic [ADDR_W-1:0] term_pos;
  logic [LEN_W-1:0]  give;
  logic              ovf;
  logic              line_hit;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              acc;
  logic              out_free;
  logic              hit;
  logic              issue;
  logic [CNT_W-1:0]  p_c;
  logic [CNT_W-1:0]  len_c;
  logic              long_c;
  logic [LEN_W-1:0]  give_c;
  logic              last_byte;
  logic              load_one;
  logic              load_byte;
  logic              finish;

  assign s_axis_tready = (state == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign hit    = (state == S_SEARCH) && rd_pend && (ram_rdata == term);
  assign issue  = (state == S_SEARCH) && (idx < count) && !hit;
  assign p_c    = idx - CNT_W'(1);
  assign len_c  = (p_c == '0) ? '0 : p_c - CNT_W'(1);
  assign long_c = (len_c > CNT_W'(MAX_LINE));
  assign give_c = long_c ? MAX_LINE : LEN_W'(len_c);

  assign last_byte = ((LEN_W'(idx) + LEN_W'(1)) == give);
  assign load_one  = (state == S_EMIT_ONE) && out_free;
  assign load_byte = (state == S_EMIT_WR) && out_free;
  assign finish    = load_one || (load_byte && last_byte);

  assign ram_we    = acc && !s_axis_tuser && !stopped && (s_axis_tdata != NUL_BYTE) &&
                     (count < CNT_W'(BUF_DEPTH));
  assign ram_waddr = wrap_addr(head, count);
  assign ram_re    = issue || (state == S_EMIT_RD);
  assign ram_raddr = wrap_addr(head, idx);

  la_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_axis_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      rd_pend       <= 1'b0;
      head          <= '0;
      count         <= '0;
      stopped       <= 1'b0;
      dropped       <= 1'b0;
      term          <= TERM_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        term <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (acc && !s_axis_tuser) begin
            if (!stopped) begin
              if (s_axis_tdata == NUL_BYTE) begin
                if (!s_axis_tlast) begin
                  stopped <= 1'b1;
                end
              end else if (count < CNT_W'(BUF_DEPTH)) begin
                count <= count + CNT_W'(1);
              end else begin
                dropped <= 1'b1;
              end
            end
            if (s_axis_tlast) begin
              stopped <= 1'b0;
              idx     <= '0;
              rd_pend <= 1'b0;
              state   <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            term_pos <= ADDR_W'(p_c);
            give     <= give_c;
            ovf      <= dropped || long_c;
            line_hit <= 1'b1;
            idx      <= '0;
            rd_pend  <= 1'b0;
            state    <= (give_c == '0) ? S_EMIT_ONE : S_EMIT_RD;
          end else if ((idx == count) && !rd_pend) begin
            give     <= '0;
            ovf      <= dropped;
            line_hit <= 1'b0;
            state    <= S_EMIT_ONE;
          end else begin
            rd_pend <= issue;
            if (issue) begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (load_byte && !last_byte) begin
            idx   <= idx + CNT_W'(1);
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_ONE: begin
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load_one || load_byte) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (finish) begin
        dropped <= 1'b0;
        state   <= S_IDLE;
        if (line_hit) begin
          head  <= wrap_addr(head, CNT_W'(term_pos) + CNT_W'(1));
          count <= count - (CNT_W'(term_pos) + CNT_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_one) begin
      m_axis_tdata <= {1'b0, ovf, {LEN_W{1'b0}}, NUL_BYTE};
      m_axis_tlast <= 1'b1;
      m_axis_tuser <= line_hit;
    end else if (load_byte) begin
      m_axis_tdata <= {1'b0, ovf, give, ram_rdata};
      m_axis_tlast <= last_byte;
      m_axis_tuser <= 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BUF_DEPTH))
    else $error("fill count exceeds buffer depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (idx <= count))
    else $error("scan index past fill count");

  a_chunk_end: assert property (@(posedge clk) disable iff (rst)
    (acc && s_axis_tlast && !s_axis_tuser) |=> (state == S_SEARCH) && !stopped)
    else $error("chunk end did not start scan");

  a_no_line: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[13:8] == '0)))
    else $error("no-line result malformed");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_WR) |-> (give != '0) && (LEN_W'(idx) < give))
    else $error("emit index outside line");

endmodule
